### src/u8v_pkg.sv
package u8v_pkg;

	// Limits of the code space and of the surrogate ranges.
	localparam int unsigned CpWidth = 21;
	localparam logic [CpWidth-1:0] CpMax    = 21'h10FFFF;
	localparam logic [CpWidth-1:0] HiSurLo  = 21'h00D800;
	localparam logic [CpWidth-1:0] HiSurHi  = 21'h00DBFF;
	localparam logic [CpWidth-1:0] LoSurLo  = 21'h00DC00;
	localparam logic [CpWidth-1:0] LoSurHi  = 21'h00DFFF;

	// Byte class masks.
	localparam logic [7:0] LeadBad   = 8'hF8;
	localparam logic [7:0] Lead4Mask = 8'hF0;
	localparam logic [7:0] Lead3Mask = 8'hE0;
	localparam logic [7:0] Lead2Mask = 8'hC0;
	localparam logic [7:0] ContMark  = 8'h80;
	localparam logic [7:0] ContBits  = 8'h3F;

	// One input transaction.
	typedef struct packed {
		logic [7:0] byte_value;
		logic       has_byte;
		logic       end_of_string;
	} u8v_in_t;

	// One result transaction.
	typedef struct packed {
		logic string_done;
		logic string_valid;
	} u8v_out_t;

	// Decoder state carried from byte to byte.
	typedef struct packed {
		logic [1:0]         bytes_pending;
		logic [CpWidth-1:0] code_point_acc;
		logic               awaiting_low_surrogate;
		logic               error_seen;
	} u8v_state_t;

endpackage

### src/u8v_step.sv
module u8v_step
	import u8v_pkg::*;
(
	input  u8v_state_t state,
	input  u8v_in_t    item,
	output u8v_state_t state_next,
	output u8v_out_t   result
);

	// Surrogate pairing and range check on a finished code point.
	function automatic u8v_state_t finish_cp(u8v_state_t s, logic [CpWidth-1:0] cp);
		u8v_state_t r;
		logic       hi;
		logic       lo;
		r  = s;
		hi = (cp >= HiSurLo) && (cp <= HiSurHi);
		lo = (cp >= LoSurLo) && (cp <= LoSurHi);
		if (cp > CpMax) begin
			r.error_seen = 1'b1;
		end else if (s.awaiting_low_surrogate) begin
			if (!lo) begin
				r.error_seen = 1'b1;
			end
			r.awaiting_low_surrogate = 1'b0;
		end else if (lo) begin
			r.error_seen = 1'b1;
		end else begin
			r.awaiting_low_surrogate = hi;
		end
		return r;
	endfunction

	u8v_state_t         after_byte;
	u8v_state_t         after_end;
	logic [7:0]         c;
	logic [CpWidth-1:0] cont_bits;
	logic [CpWidth-1:0] acc_merged;

	assign c = item.byte_value;

	// Continuation payload placed at the slot the pending count selects.
	always_comb begin
		case (state.bytes_pending)
			2'd3:    cont_bits = CpWidth'({c & ContBits, 12'd0});
			2'd2:    cont_bits = CpWidth'({c & ContBits, 6'd0});
			default: cont_bits = CpWidth'(c & ContBits);
		endcase
		acc_merged = state.code_point_acc | cont_bits;
	end

	// Byte decode: lead byte classification or continuation gathering.
	always_comb begin
		after_byte = state;
		if (item.has_byte && !state.error_seen) begin
			if (state.bytes_pending == 2'd0) begin
				if (!c[7]) begin
					after_byte = finish_cp(state, CpWidth'(c));
				end else if (c >= LeadBad) begin
					after_byte.error_seen = 1'b1;
				end else if ((c & Lead4Mask) == Lead4Mask) begin
					after_byte.code_point_acc = CpWidth'({c[2:0], 18'd0});
					after_byte.bytes_pending  = 2'd3;
				end else if ((c & Lead3Mask) == Lead3Mask) begin
					after_byte.code_point_acc = CpWidth'({c[3:0], 12'd0});
					after_byte.bytes_pending  = 2'd2;
				end else if ((c & Lead2Mask) == Lead2Mask) begin
					after_byte.code_point_acc = CpWidth'({c[4:0], 6'd0});
					after_byte.bytes_pending  = 2'd1;
				end else begin
					after_byte.error_seen = 1'b1;
				end
			end else if ((c & Lead2Mask) != ContMark) begin
				after_byte.error_seen = 1'b1;
			end else begin
				after_byte.code_point_acc = acc_merged;
				after_byte.bytes_pending  = state.bytes_pending - 2'd1;
				if (state.bytes_pending == 2'd1) begin
					after_byte = finish_cp(after_byte, acc_merged);
				end
			end
		end
	end

	// End of string: pending sequence or unpaired high surrogate fails.
	always_comb begin
		after_end = after_byte;
		if (item.end_of_string &&
		    ((after_byte.bytes_pending != 2'd0) || after_byte.awaiting_low_surrogate)) begin
			after_end.error_seen = 1'b1;
		end
		result.string_done  = item.end_of_string;
		result.string_valid = !after_end.error_seen;
		state_next = item.end_of_string ? '0 : after_end;
	end

endmodule

### src/utf8_stream_validator.sv
// UTF-8 stream validator. Bytes of a string arrive one transaction each on the
// byte channel; every transaction yields one verdict transaction that tells
// whether the string is still valid, and the transaction flagged end_of_string
// carries the final verdict and clears the decoder for the next string. An end
// flag without a byte closes a string (an empty string is valid). The block
// takes one transaction per clock cycle unless a waiting verdict stalls it. A
// byte is decoded straight out of the input register, and its verdict is loaded
// into the result register once that register is free or draining. The
// throughput is set by the decoder state register, which is updated from the
// registered byte. A verdict that waits for the receiver holds the input
// register, so at most two transactions are in flight.
module utf8_stream_validator
	import u8v_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	output logic     byte_ready,
	input  u8v_in_t  byte_item,
	output logic     verdict_valid,
	input  logic     verdict_ready,
	output u8v_out_t verdict_item
);

	logic       valid_s1;
	u8v_in_t    item_s1;
	logic       advance;
	u8v_state_t state_q;
	u8v_state_t state_next;
	u8v_out_t   result;

	// The registered byte moves on when the result register is free or draining.
	assign advance    = valid_s1 && (!verdict_valid || verdict_ready);
	assign byte_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			item_s1 <= byte_item;
		end
	end

	u8v_step u_step (
		.state      (state_q),
		.item       (item_s1),
		.state_next (state_next),
		.result     (result)
	);

	// Decoder state advances once per transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_valid <= 1'b0;
		end else if (advance) begin
			verdict_valid <= 1'b1;
		end else if (verdict_ready) begin
			verdict_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			verdict_item <= result;
		end
	end

	// A string that ends leaves the decoder clean.
	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.end_of_string |=> state_q == '0)
		else $error("decoder state not cleared after end of string");

	// An error sticks until the string ends.
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		advance && state_q.error_seen && !item_s1.end_of_string |=> state_q.error_seen)
		else $error("error flag dropped inside a string");

	// A stalled input register means the result register is full and blocked.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> valid_s1 && verdict_valid && !verdict_ready)
		else $error("input stalled without a blocked result");

	// The reported verdict matches the state it left behind within a string.
	a_verdict_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !item_s1.end_of_string |=> verdict_item.string_valid == !state_q.error_seen)
		else $error("verdict disagrees with decoder error state");

endmodule

### tb/utf8_stream_validator_tb.sv
module utf8_stream_validator_tb;
	import u8v_pkg::*;

	localparam int CycleLimit = 400000;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     byte_valid = 1'b0;
	logic     byte_ready;
	u8v_in_t  byte_item = '0;
	logic     verdict_valid;
	logic     verdict_ready = 1'b0;
	u8v_out_t verdict_item;

	// Expected verdicts in the order their bytes were accepted.
	u8v_out_t expected_verdicts[$];
	// Items of the string under construction, end flag not yet set.
	u8v_in_t  str_items[$];

	int error_count = 0;
	int cycle_count = 0;
	int counted_items = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;

	// Decoder state of the predictor.
	logic [1:0]         dec_pending = '0;
	logic [CpWidth-1:0] dec_cp = '0;
	logic               dec_wait_low = 1'b0;
	logic               dec_failed = 1'b0;

	utf8_stream_validator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_ready    (byte_ready),
		.byte_item     (byte_item),
		.verdict_valid (verdict_valid),
		.verdict_ready (verdict_ready),
		.verdict_item  (verdict_item)
	);

	// Clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// The receiver stalls at random according to the current phase.
	always @(posedge clk) begin
		verdict_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Compare each accepted verdict transaction with the oldest expectation.
	always @(posedge clk) begin
		u8v_out_t want;
		if (arst_n && verdict_valid && verdict_ready) begin
			if (expected_verdicts.size() == 0) begin
				$display("%0t: unexpected verdict: expected none, got done=%0b valid=%0b",
					$time, verdict_item.string_done, verdict_item.string_valid);
				error_count++;
			end else begin
				want = expected_verdicts.pop_front();
				if (verdict_item.string_done !== want.string_done ||
				    verdict_item.string_valid !== want.string_valid) begin
					$display("%0t: mismatch: expected done=%0b valid=%0b, got done=%0b valid=%0b",
						$time, want.string_done, want.string_valid,
						verdict_item.string_done, verdict_item.string_valid);
					error_count++;
				end
			end
		end
	end

	// A completed code point: range check and surrogate pairing.
	function automatic void close_code_point(logic [CpWidth-1:0] cp);
		logic hi;
		logic lo;
		hi = (cp >= HiSurLo) && (cp <= HiSurHi);
		lo = (cp >= LoSurLo) && (cp <= LoSurHi);
		if (cp > CpMax) begin
			dec_failed = 1'b1;
		end else if (dec_wait_low) begin
			if (!lo)
				dec_failed = 1'b1;
			dec_wait_low = 1'b0;
		end else if (lo) begin
			dec_failed = 1'b1;
		end else begin
			dec_wait_low = hi;
		end
	endfunction

	// One byte through the decoder: lead byte or continuation byte.
	function automatic void decode_byte(logic [7:0] b);
		if (dec_pending == 2'd0) begin
			if (b < ContMark) begin
				close_code_point({13'd0, b});
			end else if (b >= LeadBad) begin
				dec_failed = 1'b1;
			end else if ((b & Lead4Mask) == Lead4Mask) begin
				dec_cp = {b[2:0], 18'd0};
				dec_pending = 2'd3;
			end else if ((b & Lead3Mask) == Lead3Mask) begin
				dec_cp = {5'd0, b[3:0], 12'd0};
				dec_pending = 2'd2;
			end else if ((b & Lead2Mask) == Lead2Mask) begin
				dec_cp = {10'd0, b[4:0], 6'd0};
				dec_pending = 2'd1;
			end else begin
				dec_failed = 1'b1;
			end
		end else if ((b & Lead2Mask) != ContMark) begin
			dec_failed = 1'b1;
		end else begin
			dec_cp = dec_cp | (CpWidth'(b & ContBits) << ((int'(dec_pending) - 1) * 6));
			dec_pending = dec_pending - 2'd1;
			if (dec_pending == 2'd0)
				close_code_point(dec_cp);
		end
	endfunction

	// Verdict for one accepted transaction; updates the decoder state.
	function automatic u8v_out_t predict_verdict(u8v_in_t it);
		u8v_out_t r;
		if (it.has_byte && !dec_failed)
			decode_byte(it.byte_value);
		if (it.end_of_string && (dec_pending != 2'd0 || dec_wait_low))
			dec_failed = 1'b1;
		r.string_done = it.end_of_string;
		r.string_valid = !dec_failed;
		if (it.end_of_string) begin
			dec_pending = '0;
			dec_cp = '0;
			dec_wait_low = 1'b0;
			dec_failed = 1'b0;
		end
		return r;
	endfunction

	// Send one transaction, with random idle cycles before it.
	task automatic send_item(u8v_in_t it);
		if ($urandom_range(99) < sender_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < sender_idle_pct)
				@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item <= it;
		@(posedge clk);
		while (!byte_ready)
			@(posedge clk);
		counted_items++;
		expected_verdicts.insert(expected_verdicts.size(), predict_verdict(it));
	endtask

	function automatic void push_byte(logic [7:0] b);
		u8v_in_t it;
		it.byte_value = b;
		it.has_byte = 1'b1;
		it.end_of_string = 1'b0;
		str_items.insert(str_items.size(), it);
	endfunction

	// A transaction that carries neither a byte nor an end flag.
	function automatic void push_blank();
		u8v_in_t it;
		it.byte_value = 8'($urandom_range(0, 255));
		it.has_byte = 1'b0;
		it.end_of_string = 1'b0;
		str_items.insert(str_items.size(), it);
	endfunction

	// Encode a code point in len bytes; a longer len than needed is overlong.
	function automatic void push_code_point(logic [CpWidth-1:0] cp, int len);
		case (len)
			1: push_byte({1'b0, cp[6:0]});
			2: begin
				push_byte({3'b110, cp[10:6]});
				push_byte({2'b10, cp[5:0]});
			end
			3: begin
				push_byte({4'b1110, cp[15:12]});
				push_byte({2'b10, cp[11:6]});
				push_byte({2'b10, cp[5:0]});
			end
			default: begin
				push_byte({5'b11110, cp[20:18]});
				push_byte({2'b10, cp[17:12]});
				push_byte({2'b10, cp[11:6]});
				push_byte({2'b10, cp[5:0]});
			end
		endcase
	endfunction

	// Send the built string; the end flag rides on the last byte or on an
	// end-only transaction of its own.
	task automatic send_string(bit end_only);
		u8v_in_t closing;
		if (end_only || str_items.size() == 0) begin
			closing.byte_value = 8'($urandom_range(0, 255));
			closing.has_byte = 1'b0;
			closing.end_of_string = 1'b1;
			str_items.insert(str_items.size(), closing);
		end else begin
			str_items[str_items.size() - 1].end_of_string = 1'b1;
		end
		while (str_items.size() != 0)
			send_item(str_items.pop_front());
	endtask

	// Empty string, ASCII extremes and well-formed multibyte forms.
	task automatic test_basic_sequences();
		send_string(1'b1);
		push_byte(8'h00);
		push_byte(8'h7F);
		send_string(1'b0);
		push_code_point(21'h0000A9, 2);
		push_code_point(21'h01F600, 4);
		send_string(1'b0);
	endtask

	// A proper pair, a lone low half and a high half left open at the end.
	task automatic test_surrogate_pairs();
		push_code_point(HiSurLo, 3);
		push_code_point(LoSurLo, 3);
		send_string(1'b0);
		push_code_point(LoSurLo, 3);
		send_string(1'b0);
		push_code_point(HiSurHi, 3);
		send_string(1'b1);
	endtask

	// Forbidden lead byte with a byte after it, a stray continuation byte and
	// a code point beyond the top of the code space.
	task automatic test_illegal_bytes();
		push_byte(8'hF8);
		push_byte(8'h41);
		send_string(1'b0);
		push_byte(8'h80);
		send_string(1'b0);
		push_code_point(21'h110000, 4);
		send_string(1'b0);
	endtask

	// A sequence cut short by the end of the string, with a blank transaction
	// inside it that must change nothing.
	task automatic test_truncation();
		push_byte(8'hC2);
		push_blank();
		send_string(1'b1);
	endtask

	// Random strings, mostly well formed with random content, the rest noise,
	// cut sequences, stray surrogates and blank transactions.
	task automatic test_random_strings(int item_goal);
		int start_count;
		int units;
		int pick;
		int len;
		start_count = counted_items;
		while (counted_items - start_count < item_goal) begin
			units = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 6);
			repeat (units) begin
				pick = $urandom_range(99);
				if (pick < 30) begin
					push_code_point(21'($urandom_range(0, 'h7F)), 1);
				end else if (pick < 45) begin
					push_code_point(21'($urandom_range(($urandom_range(9) == 0) ? 0 : 'h80,
						'h7FF)), 2);
				end else if (pick < 60) begin
					push_code_point(21'($urandom_range(0, 'hFFFF)), 3);
				end else if (pick < 72) begin
					if ($urandom_range(99) < 85)
						push_code_point(21'($urandom_range('h10000, 'h10FFFF)), 4);
					else
						push_code_point(21'($urandom_range(0, 'h1FFFFF)), 4);
				end else if (pick < 82) begin
					push_code_point(21'($urandom_range('hD800, 'hDBFF)), 3);
					push_code_point(21'($urandom_range('hDC00, 'hDFFF)), 3);
				end else if (pick < 86) begin
					if ($urandom_range(1) == 0)
						push_code_point(21'($urandom_range('hDC00, 'hDFFF)), 3);
					else
						push_code_point(21'($urandom_range('hD800, 'hDBFF)), 3);
				end else if (pick < 92) begin
					push_byte(8'($urandom_range(0, 255)));
				end else if (pick < 96) begin
					len = $urandom_range(2, 4);
					push_code_point(21'($urandom_range(0, 'h1FFFFF)), len);
					repeat ($urandom_range(1, len - 1))
						void'(str_items.pop_back());
				end else begin
					push_blank();
				end
			end
			send_string($urandom_range(99) < 20);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_sequences();
		test_surrogate_pairs();
		test_illegal_bytes();
		test_truncation();

		// Random strings across the idling phases.
		test_random_strings(325);
		sender_idle_pct = 78;
		test_random_strings(325);
		sender_idle_pct = 0;
		receiver_stall_pct = 78;
		test_random_strings(325);
		sender_idle_pct = 38;
		receiver_stall_pct = 38;
		test_random_strings(325);

		byte_valid <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
